FILE: hdl/utc_pkg.sv
package utc_pkg;

  localparam int PIX_W   = 8;
  localparam int IMG_W   = 13;
  localparam int TILE_W  = 9;
  localparam int POS_W   = 12;
  localparam int INTL_W  = 8;
  localparam int IDX_W   = 25;

  localparam logic [IMG_W-1:0]  IMG_MAX  = 13'd4096;
  localparam logic [TILE_W-1:0] TILE_MAX = 9'd256;
  localparam logic [IDX_W-1:0]  PLAIN_INDEX = {IDX_W{1'b1}};

  // register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TILE_WIDTH   = 2'd2;
  localparam logic [1:0] REG_TILE_HEIGHT  = 2'd3;

  typedef struct packed {
    logic             plain;
    logic [PIX_W-1:0] colour;
  } col_entry_t;

  typedef struct packed {
    logic              active;
    logic              first;
    logic              emit;
    logic              last;
    logic              fs;
    logic [PIX_W-1:0]  pix;
    logic [POS_W-1:0]  col;
  } stage_t;

  function automatic logic [IMG_W-1:0] clamp_img(input logic [IMG_W-1:0] v);
    logic [IMG_W-1:0] r;
    if (v == '0) r = 13'd1;
    else if (v > IMG_MAX) r = IMG_MAX;
    else r = v;
    return r;
  endfunction

  function automatic logic [TILE_W-1:0] clamp_tile(input logic [TILE_W-1:0] v);
    logic [TILE_W-1:0] r;
    if (v == '0) r = 9'd1;
    else if (v > TILE_MAX) r = TILE_MAX;
    else r = v;
    return r;
  endfunction

endpackage

FILE: hdl/uniform_tile_classifier_top.sv
// A tile record is valid on m_tvalid after the tile's last pixel is accepted, passes the
//   column store read (registered on accept) and is merged into the output register.
// One pixel per cycle when not stalled; the column store read/write-back is forwarded.
// After rst and after every register write, tile column and row limits are recomputed
//   by a 13-step shift/subtract divider; s_tready stays low until the calculation is idle.
// rst is synchronous; it clears counters and restores register defaults, not the column store.
module uniform_tile_classifier_top #(
  parameter int MAX_TILE_COLUMNS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel
  input  logic        s_tuser,   // [0] frame_start
  // tile records
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] tile_colour, [32:8] data_index, zero fill above
  output logic        m_tuser,   // [0] plain
  output logic        m_tlast    // frame_last
);
  import utc_pkg::*;

  localparam int AW = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;
  localparam logic [IMG_W-1:0] MAX_COLS = IMG_W'(MAX_TILE_COLUMNS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // configuration registers
  logic [IMG_W-1:0]  image_width, image_height;
  logic [TILE_W-1:0] tile_width, tile_height;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd640;
      image_height <= 13'd480;
      tile_width   <= 9'd16;
      tile_height  <= 9'd16;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[IMG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[IMG_W-1:0];
        REG_TILE_WIDTH:   tile_width   <= pwdata[TILE_W-1:0];
        REG_TILE_HEIGHT:  tile_height  <= pwdata[TILE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IMAGE_WIDTH:  prdata = {19'd0, image_width};
      REG_IMAGE_HEIGHT: prdata = {19'd0, image_height};
      REG_TILE_WIDTH:   prdata = {23'd0, tile_width};
      REG_TILE_HEIGHT:  prdata = {23'd0, tile_height};
      default:          prdata = '0;
    endcase
  end

  logic [IMG_W-1:0]  w_c, h_c;
  logic [TILE_W-1:0] tw_c, th_c;

  assign w_c  = clamp_img(image_width);
  assign h_c  = clamp_img(image_height);
  assign tw_c = clamp_tile(tile_width);
  assign th_c = clamp_tile(tile_height);

  // limit computation: cols = min(w / tw, MAX_COLS), tiled_h = (h / th) * th
  logic [1:0]        calc_state;
  logic [3:0]        div_cnt;
  logic [IMG_W-1:0]  qw, qh;
  logic [INTL_W-1:0] rw, rh;
  logic [TILE_W-1:0] tw_rem, th_rem;
  logic [21:0]       tiled_prod;
  logic [IMG_W-1:0]  cols, tiled_h;

  assign tw_rem = {rw, qw[IMG_W-1]};
  assign th_rem = {rh, qh[IMG_W-1]};
  assign tiled_prod = qh * th_c;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      calc_state <= S_LOAD;
      div_cnt    <= '0;
    end else begin
      case (calc_state)
        S_LOAD: begin
          qw <= w_c;
          qh <= h_c;
          rw <= '0;
          rh <= '0;
          div_cnt <= '0;
          calc_state <= S_DIV;
        end
        S_DIV: begin
          if (tw_rem >= tw_c) begin
            rw <= INTL_W'(tw_rem - tw_c);
            qw <= {qw[IMG_W-2:0], 1'b1};
          end else begin
            rw <= tw_rem[INTL_W-1:0];
            qw <= {qw[IMG_W-2:0], 1'b0};
          end
          if (th_rem >= th_c) begin
            rh <= INTL_W'(th_rem - th_c);
            qh <= {qh[IMG_W-2:0], 1'b1};
          end else begin
            rh <= th_rem[INTL_W-1:0];
            qh <= {qh[IMG_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'(IMG_W - 1)) calc_state <= S_FIN;
        end
        S_FIN: begin
          cols       <= (qw > MAX_COLS) ? MAX_COLS : qw;
          tiled_h    <= tiled_prod[IMG_W-1:0];
          calc_state <= S_IDLE;
        end
        default: calc_state <= S_IDLE;
      endcase
    end
  end

  // raster position
  logic [POS_W-1:0]  pixel_x, pixel_y, tile_column;
  logic [INTL_W-1:0] x_in_tile, y_in_tile;
  logic [POS_W-1:0]  px_e, py_e, tc_e;
  logic [INTL_W-1:0] xt_e, yt_e;
  logic [POS_W-1:0]  pixel_x_next, pixel_y_next, tile_column_next;
  logic [INTL_W-1:0] x_in_tile_next, y_in_tile_next;
  logic [TILE_W-1:0] xt_inc, yt_inc;
  logic              accept;
  stage_t            s0, s1;
  logic              s1_valid, s1_adv;

  assign accept = s_tvalid & s_tready;

  always_comb begin
    px_e = s_tuser ? '0 : pixel_x;
    py_e = s_tuser ? '0 : pixel_y;
    tc_e = s_tuser ? '0 : tile_column;
    xt_e = s_tuser ? '0 : x_in_tile;
    yt_e = s_tuser ? '0 : y_in_tile;
    xt_inc = {1'b0, xt_e} + 9'd1;
    yt_inc = {1'b0, yt_e} + 9'd1;

    s0.active = ({1'b0, tc_e} < cols) && ({1'b0, py_e} < tiled_h);
    s0.first  = (xt_e == '0) && (yt_e == '0);
    s0.emit   = s0.active && (xt_inc >= tw_c) && (yt_inc >= th_c);
    s0.last   = (({1'b0, tc_e} + 13'd1) == cols) && (({1'b0, py_e} + 13'd1) == tiled_h);
    s0.fs     = s_tuser;
    s0.pix    = s_tdata;
    s0.col    = tc_e;

    tile_column_next = tc_e;
    if (xt_inc >= tw_c) begin
      x_in_tile_next   = '0;
      tile_column_next = tc_e + 12'd1;
    end else begin
      x_in_tile_next = xt_inc[INTL_W-1:0];
    end
    y_in_tile_next = yt_e;
    pixel_y_next   = py_e;
    if (({1'b0, px_e} + 13'd1) >= w_c) begin
      pixel_x_next     = '0;
      x_in_tile_next   = '0;
      tile_column_next = '0;
      y_in_tile_next   = (yt_inc >= th_c) ? '0 : yt_inc[INTL_W-1:0];
      if (({1'b0, py_e} + 13'd1) >= h_c) begin
        pixel_y_next   = '0;
        y_in_tile_next = '0;
      end else begin
        pixel_y_next = py_e + 12'd1;
      end
    end else begin
      pixel_x_next = px_e + 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_x     <= '0;
      pixel_y     <= '0;
      x_in_tile   <= '0;
      y_in_tile   <= '0;
      tile_column <= '0;
    end else if (accept) begin
      pixel_x     <= pixel_x_next;
      pixel_y     <= pixel_y_next;
      x_in_tile   <= x_in_tile_next;
      y_in_tile   <= y_in_tile_next;
      tile_column <= tile_column_next;
    end
  end

  // column store, read on accept, written back when an active stage retires
  col_entry_t col_mem [MAX_TILE_COLUMNS];
  col_entry_t rd_entry, fwd_entry, old_entry, wr_entry;
  logic       fwd_hit, mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) col_mem[s1.col[AW-1:0]] <= wr_entry;
    if (accept) rd_entry <= col_mem[s0.col[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_hit   <= mem_we && (s1.col == s0.col);
      fwd_entry <= wr_entry;
      s1        <= s0;
    end
  end

  logic             out_valid, out_plain, out_last;
  logic [PIX_W-1:0] out_colour;
  logic [IDX_W-1:0] out_idx;
  logic [IDX_W-1:0] next_data_index, next_data_index_next, idx_base;

  assign old_entry       = fwd_hit ? fwd_entry : rd_entry;
  assign wr_entry.colour = s1.first ? s1.pix : old_entry.colour;
  assign wr_entry.plain  = s1.first | (old_entry.plain & (s1.pix == old_entry.colour));

  assign s1_adv   = s1_valid && (!s1.emit || !out_valid || m_tready);
  assign mem_we   = s1_adv && s1.active;
  assign s_tready = (calc_state == S_IDLE) && (!s1_valid || s1_adv);
  assign idx_base = s1.fs ? '0 : next_data_index;

  always_comb begin
    next_data_index_next = next_data_index;
    if (s1_adv) begin
      if (s1.emit && !wr_entry.plain) next_data_index_next = idx_base + 25'd1;
      else next_data_index_next = idx_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      next_data_index <= '0;
    end else begin
      next_data_index <= next_data_index_next;
      if (accept) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
      if (s1_adv && s1.emit) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.emit) begin
      out_plain  <= wr_entry.plain;
      out_colour <= wr_entry.colour;
      out_idx    <= wr_entry.plain ? PLAIN_INDEX : idx_base;
      out_last   <= s1.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_idx, out_colour};
  assign m_tuser  = out_plain;
  assign m_tlast  = out_last;

  // an accepted pixel behind a busy stage needs that stage to retire in the same cycle
  a_accept_retires: assert property (@(posedge clk) disable iff (rst)
    (accept && s1_valid) |-> s1_adv) else $error("accept over a stalled stage");

  a_no_accept_during_calc: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (calc_state == S_IDLE)) else $error("ready while limits recompute");

  a_cols_bound: assert property (@(posedge clk) disable iff (rst)
    (calc_state == S_IDLE) |-> (cols <= MAX_COLS)) else $error("cols above store depth");

  a_plain_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[32:8] == PLAIN_INDEX))
    else $error("plain record without all-ones index");

  a_write_only_active: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (s1_valid && ({1'b0, s1.col} < MAX_COLS)))
    else $error("column store write outside the store");

endmodule
